@@ rtl/core/zyz_euler_rotation_matrix_top_macros.svh @@
// Assertion helpers for the RTL of the rotation matrix block.
`ifndef ZYZ_EULER_ROTATION_MATRIX_TOP_MACROS_SVH
`define ZYZ_EULER_ROTATION_MATRIX_TOP_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define ZYZR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ZYZR_ASSERT(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/zyzr_pkg.sv @@
package zyzr_pkg;

	localparam longint PIH_Q30  = 64'sd1686629713;
	localparam longint HALF_PIH = 64'sd843314856;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint ONE_Q30  = 64'sd1073741824;
	localparam int     TABLE_LEN = 30;
	localparam int     AW = 35;
	localparam int     NTH = 6;

	typedef struct packed {
		logic       vld;
		logic [1:0] quad;
	} cdc_ctl_t;

	function automatic longint atan_q30(input int i);
		longint v;
		unique case (i)
			0:  v = 64'sh3243F6A8;
			1:  v = 64'sh1DAC6705;
			2:  v = 64'sh0FADBAFC;
			3:  v = 64'sh07F56EA6;
			4:  v = 64'sh03FEAB76;
			5:  v = 64'sh01FFD55B;
			6:  v = 64'sh00FFFAAA;
			7:  v = 64'sh007FFF55;
			8:  v = 64'sh003FFFEA;
			9:  v = 64'sh001FFFFD;
			10: v = 64'sh000FFFFF;
			11: v = 64'sh0007FFFF;
			12: v = 64'sh0003FFFF;
			13: v = 64'sh0001FFFF;
			14: v = 64'sh0000FFFF;
			15: v = 64'sh00007FFF;
			16: v = 64'sh00003FFF;
			17: v = 64'sh00001FFF;
			18: v = 64'sh00000FFF;
			19: v = 64'sh000007FF;
			20: v = 64'sh000003FF;
			21: v = 64'sh000001FF;
			22: v = 64'sh000000FF;
			23: v = 64'sh0000007F;
			24: v = 64'sh0000003F;
			25: v = 64'sh0000001F;
			26: v = 64'sh0000000F;
			27: v = 64'sh00000008;
			28: v = 64'sh00000004;
			29: v = 64'sh00000002;
			default: v = 64'sd0;
		endcase
		return v;
	endfunction

	// Magnitude at or above this value rounds to j quarter turns or more.
	function automatic logic [AW-1:0] red_thresh(input int j);
		return AW'(longint'(j - 1) * PIH_Q30 + HALF_PIH + 64'sd1);
	endfunction

	function automatic logic [AW-1:0] kpih(input logic [2:0] k);
		return AW'(longint'(k) * PIH_Q30);
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = 34'(ONE_Q30);
		lo = -34'(ONE_Q30);
		if (v > hi) return 32'(ONE_Q30);
		if (v < lo) return -32'(ONE_Q30);
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] rnd(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p + 64'sd536870912;
		return s[61:30];
	endfunction

endpackage

@@ rtl/core/zyzr_cordic.sv @@
module zyzr_cordic #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  zyzr_pkg::cdc_ctl_t     ctl_in,
	input  logic signed [32:0]     z_in,
	output zyzr_pkg::cdc_ctl_t     ctl_out,
	output logic signed [31:0]     cos_out,
	output logic signed [31:0]     sin_out
);
	import zyzr_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

	cdc_ctl_t           ctl_s [1:NSTEP];
	logic signed [33:0] x_s [1:NSTEP];
	logic signed [33:0] y_s [1:NSTEP];
	logic signed [32:0] z_s [1:NSTEP];
	cdc_ctl_t           ctl_q;
	logic signed [31:0] cos_q;
	logic signed [31:0] sin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NSTEP; i++) begin
				ctl_s[i] <= '0;
			end
			ctl_q <= '0;
		end else begin
			ctl_s[1] <= ctl_in;
			for (int i = 2; i <= NSTEP; i++) begin
				ctl_s[i] <= ctl_s[i-1];
			end
			ctl_q <= ctl_s[NSTEP];
		end
	end

	// One micro-rotation per stage; shifts are fixed per stage.
	// The first rotation starts from (gain, 0), so only y and z depend on the sign.
	always_ff @(posedge clk) begin
		x_s[1] <= 34'(GAIN_Q30);
		if (z_in >= 0) begin
			y_s[1] <= 34'(GAIN_Q30);
			z_s[1] <= z_in - 33'(atan_q30(0));
		end else begin
			y_s[1] <= -34'(GAIN_Q30);
			z_s[1] <= z_in + 33'(atan_q30(0));
		end
		for (int i = 1; i < NSTEP; i++) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - 33'(atan_q30(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + 33'(atan_q30(i));
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl_s[NSTEP].quad)
			2'd0: begin
				cos_q <= sat34(x_s[NSTEP]);
				sin_q <= sat34(y_s[NSTEP]);
			end
			2'd1: begin
				cos_q <= sat34(-y_s[NSTEP]);
				sin_q <= sat34(x_s[NSTEP]);
			end
			2'd2: begin
				cos_q <= sat34(-x_s[NSTEP]);
				sin_q <= sat34(-y_s[NSTEP]);
			end
			default: begin
				cos_q <= sat34(y_s[NSTEP]);
				sin_q <= sat34(-x_s[NSTEP]);
			end
		endcase
	end

	assign ctl_out = ctl_q;
	assign cos_out = cos_q;
	assign sin_out = sin_q;

endmodule

@@ rtl/core/zyz_euler_rotation_matrix_top.sv @@
// ZYZ Euler angles to rotation matrix, fully pipelined.
// Input: drive func, zeta, kappa and eta (radians times 2^28) and raise start
// for one cycle per beat. busy is always low, so a beat is taken every cycle.
// func low gives the rotation matrix; func high gives the mid-step frame,
// with kappa halved and the third angle set to (eta - zeta)/2.
// Output: done is high for exactly one cycle with m00..m22 (row-major,
// Q2.30, saturated to plus or minus one). The receiver cannot stall.
// From start to done, a beat passes through the quadrant reduction registers,
// the CORDIC micro-rotation stages, the quadrant mapping register and the
// registers of the two rounds of multiplies. Throughput is one beat per clock;
// the three CORDIC pipelines and the multiplier stages each take a new angle
// set every cycle.
// Reset clears every valid bit, so nothing in flight comes out afterwards.
`include "zyz_euler_rotation_matrix_top_macros.svh"

module zyz_euler_rotation_matrix_top #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic signed [31:0] zeta,
	input  logic signed [31:0] kappa,
	input  logic signed [31:0] eta,
	output logic               done,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12,
	output logic signed [31:0] m20,
	output logic signed [31:0] m21,
	output logic signed [31:0] m22
);
	import zyzr_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int LAT = NSTEP + 8;

	logic signed [AW-1:0] ang [0:2];
	logic signed [AW-1:0] zeta_x, kappa_x, eta_x, diff;

	logic                 vld_s1, vld_s2, vld_s3;
	logic                 neg_s1 [0:2];
	logic [AW-1:0]        mag_s1 [0:2];
	logic                 neg_s2 [0:2];
	logic [AW-1:0]        mag_s2 [0:2];
	logic [2:0]           k_s2 [0:2];
	logic signed [32:0]   z_s3 [0:2];
	logic [1:0]           quad_s3 [0:2];

	cdc_ctl_t             ctl_in [0:2];
	cdc_ctl_t             ctl_out [0:2];
	logic signed [31:0]   cs [0:2];
	logic signed [31:0]   sn [0:2];

	assign busy = 1'b0;

	assign zeta_x  = AW'(zeta);
	assign kappa_x = AW'(kappa);
	assign eta_x   = AW'(eta);
	assign diff    = eta_x - zeta_x;
	assign ang[0]  = zeta_x <<< 2;
	assign ang[1]  = func ? (kappa_x <<< 1) : (kappa_x <<< 2);
	assign ang[2]  = func ? (diff <<< 1) : (eta_x <<< 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Reduction works on the magnitude: k is the nearest quarter turn count,
	// with ties at exactly half a quarter turn kept below.
	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			logic [2:0]    k;
			logic [2:0]    kn;
			logic [AW-1:0] rm;
			logic [AW-1:0] rz;
			neg_s1[l] <= ang[l][AW-1];
			mag_s1[l] <= ang[l][AW-1] ? AW'(-ang[l]) : AW'(ang[l]);

			k = '0;
			for (int j = 1; j <= NTH; j++) begin
				if (mag_s1[l] >= red_thresh(j)) k = 3'(j);
			end
			neg_s2[l] <= neg_s1[l];
			mag_s2[l] <= mag_s1[l];
			k_s2[l]   <= k;

			rm = mag_s2[l] - kpih(k_s2[l]);
			rz = neg_s2[l] ? -rm : rm;
			kn = 3'd0 - k_s2[l];
			z_s3[l]    <= signed'(rz[32:0]);
			quad_s3[l] <= neg_s2[l] ? kn[1:0] : k_s2[l][1:0];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign ctl_in[l] = '{vld: vld_s3, quad: quad_s3[l]};
		zyzr_cordic #(
			.CORDIC_STEPS(CORDIC_STEPS)
		) u_cordic (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_in[l]),
			.z_in   (z_s3[l]),
			.ctl_out(ctl_out[l]),
			.cos_out(cs[l]),
			.sin_out(sn[l])
		);
	end

	// Lane 0 is zeta, lane 1 kappa, lane 2 the third angle.
	logic               vld_p1, vld_p2, vld_p3;
	logic signed [63:0] t_p1, u_p1, cesz_p1, sesz_p1, czsk_p1, secz_p1;
	logic signed [63:0] cecz_p1, sksz_p1, cesk_p1, sesk_p1;
	logic signed [31:0] ce_p1, se_p1, ck_p1;
	logic signed [31:0] t_p2, u_p2, cesz_p2, sesz_p2, czsk_p2, secz_p2;
	logic signed [31:0] cecz_p2, sksz_p2, cesk_p2, sesk_p2;
	logic signed [31:0] ce_p2, se_p2, ck_p2;
	logic signed [63:0] cet_p3, set_p3, ceu_p3, seu_p3;
	logic signed [31:0] cesz_p3, sesz_p3, czsk_p3, secz_p3;
	logic signed [31:0] cecz_p3, sksz_p3, cesk_p3, sesk_p3, ck_p3;
	logic               done_q;
	logic signed [31:0] m_q [0:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_p1 <= ctl_out[0].vld;
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
			done_q <= vld_p3;
		end
	end

	always_ff @(posedge clk) begin
		t_p1    <= 64'(cs[1]) * 64'(cs[0]);
		u_p1    <= 64'(cs[1]) * 64'(sn[0]);
		cesz_p1 <= 64'(cs[2]) * 64'(sn[0]);
		sesz_p1 <= 64'(sn[2]) * 64'(sn[0]);
		czsk_p1 <= 64'(cs[0]) * 64'(sn[1]);
		secz_p1 <= 64'(sn[2]) * 64'(cs[0]);
		cecz_p1 <= 64'(cs[2]) * 64'(cs[0]);
		sksz_p1 <= 64'(sn[1]) * 64'(sn[0]);
		cesk_p1 <= 64'(cs[2]) * 64'(sn[1]);
		sesk_p1 <= 64'(sn[2]) * 64'(sn[1]);
		ce_p1   <= cs[2];
		se_p1   <= sn[2];
		ck_p1   <= cs[1];

		t_p2    <= rnd(t_p1);
		u_p2    <= rnd(u_p1);
		cesz_p2 <= rnd(cesz_p1);
		sesz_p2 <= rnd(sesz_p1);
		czsk_p2 <= rnd(czsk_p1);
		secz_p2 <= rnd(secz_p1);
		cecz_p2 <= rnd(cecz_p1);
		sksz_p2 <= rnd(sksz_p1);
		cesk_p2 <= rnd(cesk_p1);
		sesk_p2 <= rnd(sesk_p1);
		ce_p2   <= ce_p1;
		se_p2   <= se_p1;
		ck_p2   <= ck_p1;

		cet_p3  <= 64'(ce_p2) * 64'(t_p2);
		set_p3  <= 64'(se_p2) * 64'(t_p2);
		ceu_p3  <= 64'(ce_p2) * 64'(u_p2);
		seu_p3  <= 64'(se_p2) * 64'(u_p2);
		cesz_p3 <= cesz_p2;
		sesz_p3 <= sesz_p2;
		czsk_p3 <= czsk_p2;
		secz_p3 <= secz_p2;
		cecz_p3 <= cecz_p2;
		sksz_p3 <= sksz_p2;
		cesk_p3 <= cesk_p2;
		sesk_p3 <= sesk_p2;
		ck_p3   <= ck_p2;

		m_q[0] <= sat34(34'(rnd(cet_p3)) - 34'(sesz_p3));
		m_q[1] <= sat34(-34'(rnd(set_p3)) - 34'(cesz_p3));
		m_q[2] <= sat34(34'(czsk_p3));
		m_q[3] <= sat34(34'(secz_p3) + 34'(rnd(ceu_p3)));
		m_q[4] <= sat34(34'(cecz_p3) - 34'(rnd(seu_p3)));
		m_q[5] <= sat34(34'(sksz_p3));
		m_q[6] <= sat34(-34'(cesk_p3));
		m_q[7] <= sat34(34'(sesk_p3));
		m_q[8] <= sat34(34'(ck_p3));
	end

	assign done = done_q;
	assign m00  = m_q[0];
	assign m01  = m_q[1];
	assign m02  = m_q[2];
	assign m10  = m_q[3];
	assign m11  = m_q[4];
	assign m12  = m_q[5];
	assign m20  = m_q[6];
	assign m21  = m_q[7];
	assign m22  = m_q[8];

	`ZYZR_ASSERT_RST(a_lat_done, clk, arst_n, start |-> ##LAT done, "beat lost in pipeline")
	`ZYZR_ASSERT_RST(a_no_ghost, clk, arst_n, !start |-> ##LAT !done, "result without a beat")
	`ZYZR_ASSERT_RST(a_m00_rng, clk, arst_n, done |-> (m00 <= 32'sd1073741824 && m00 >= -32'sd1073741824), "m00 out of range")

endmodule
